// File: design/dhcp_reply_option_parser_top_defines.svh
// ----------------------------------------------------------------------------
// dhcp reply parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DHCP_REPLY_OPTION_PARSER_TOP_DEFINES_SVH
`define DHCP_REPLY_OPTION_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define DROP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DROP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/drop_pkg.sv
// ----------------------------------------------------------------------------
// drop_pkg
// types and constants shared by the dhcp reply parser modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package drop_pkg;

  localparam int HDR_YIADDR  = 16;
  localparam int HDR_CHADDR  = 28;
  localparam int HDR_MAC_END = 34;
  localparam int OPT_START   = 240;

  localparam logic [7:0] CODE_PAD   = 8'd0;
  localparam logic [7:0] CODE_MASK  = 8'd1;
  localparam logic [7:0] CODE_DNS   = 8'd6;
  localparam logic [7:0] CODE_LEASE = 8'd51;
  localparam logic [7:0] CODE_TYPE  = 8'd53;
  localparam logic [7:0] CODE_END   = 8'hFF;

  localparam logic [7:0] TYPE_OFFER = 8'd2;
  localparam logic [7:0] TYPE_ACK   = 8'd5;

  localparam logic [1:0] WSEL_YI = 2'd0;
  localparam logic [1:0] WSEL_SI = 2'd1;
  localparam logic [1:0] WSEL_GI = 2'd2;

  typedef enum logic [1:0] {
    ACT_IGNORE  = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_APPLY   = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_WORD = 2'd1,
    CLS_MAC  = 2'd2,
    CLS_OPT  = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_t       cls;
    logic [3:0] sel;
    logic       hdr_done;
  } item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] lease_time;
    logic [31:0] dns_addr;
    logic [31:0] net_mask;
    logic [31:0] router_ip;
    logic [31:0] server_ip;
    logic [31:0] offered_ip;
    logic [7:0]  message_type;
    logic        mac_match;
    act_t        action;
  } result_t;

endpackage

// File: design/drop_front.sv
// ----------------------------------------------------------------------------
// drop_front
// tracks the byte offset and tags each byte with its header or option role
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drop_front #(
  parameter int MAX_MESSAGE_BYTES = 1500
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_data,
  input  logic           in_last,
  output logic           in_ready,
  output logic           push,
  output drop_pkg::item_t push_item,
  input  logic           q_full
);
  import drop_pkg::*;

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic          in_range;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign in_range = pos < PW'(MAX_MESSAGE_BYTES);

  always_comb begin
    push_item.data     = in_data;
    push_item.last     = in_last;
    push_item.cls      = CLS_NONE;
    push_item.sel      = 4'd0;
    push_item.hdr_done = pos >= PW'(HDR_MAC_END - 1);
    if (!in_range) begin
      push_item.cls = CLS_NONE;
    end else if (pos >= PW'(OPT_START)) begin
      push_item.cls = CLS_OPT;
    end else if (pos >= PW'(HDR_YIADDR) && pos < PW'(HDR_CHADDR)) begin
      push_item.cls = CLS_WORD;
      push_item.sel = 4'(pos - PW'(HDR_YIADDR));
    end else if (pos >= PW'(HDR_CHADDR) && pos < PW'(HDR_MAC_END)) begin
      push_item.cls = CLS_MAC;
      push_item.sel = 4'(pos - PW'(HDR_CHADDR));
    end
  end

  always_comb begin
    if (in_last) begin
      pos_next = '0;
    end else if (in_range) begin
      pos_next = pos + PW'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      pos <= pos_next;
    end
  end

endmodule

// File: design/drop_queue.sv
// ----------------------------------------------------------------------------
// drop_queue
// short fifo of tagged items between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drop_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  drop_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output drop_pkg::item_t head,
  output logic            empty
);
  import drop_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  item_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// File: design/drop_back.sv
// ----------------------------------------------------------------------------
// drop_back
// walks the option tlvs, captures fields and registers the result item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drop_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [47:0]      station_mac,
  input  drop_pkg::item_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output drop_pkg::result_t out_result
);
  import drop_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  code;
  logic [7:0]  code_next;
  logic [7:0]  remaining;
  logic [7:0]  remaining_next;
  logic [2:0]  value_index;
  logic [2:0]  value_index_next;
  logic        match;
  logic        match_next;
  logic        ended;
  logic        ended_next;
  logic [7:0]  msg_type;
  logic [7:0]  msg_type_next;
  logic [31:0] yi, yi_next;
  logic [31:0] si, si_next;
  logic [31:0] gi, gi_next;
  logic [31:0] mask, mask_next;
  logic [31:0] dns, dns_next;
  logic [31:0] lease, lease_next;
  logic        opt_live;
  logic [7:0]  b;
  logic [7:0]  mac_byte;
  result_t     result;

  assign b        = head.data;
  assign opt_live = head.cls == CLS_OPT && !ended;
  assign mac_byte = 8'(station_mac >> {head.sel[2:0], 3'b000});
  assign pop      = !empty && (!head.last || !out_valid || out_ready);

  // tlv walk
  always_comb begin
    phase_next = phase;
    if (opt_live) begin
      unique case (phase)
        PH_CODE: begin
          if (b != CODE_PAD && b != CODE_END) begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          phase_next = (b == 8'd0) ? PH_CODE : PH_VALUE;
        end
        PH_VALUE: begin
          if (remaining == 8'd1) begin
            phase_next = PH_CODE;
          end
        end
        default: phase_next = PH_CODE;
      endcase
    end
  end

  always_comb begin
    code_next        = code;
    remaining_next   = remaining;
    value_index_next = value_index;
    match_next       = match;
    ended_next       = ended;
    msg_type_next    = msg_type;
    yi_next          = yi;
    si_next          = si;
    gi_next          = gi;
    mask_next        = mask;
    dns_next         = dns;
    lease_next       = lease;
    unique case (head.cls)
      CLS_WORD: begin
        unique case (head.sel[3:2])
          WSEL_YI: yi_next[{head.sel[1:0], 3'b000} +: 8] = b;
          WSEL_SI: si_next[{head.sel[1:0], 3'b000} +: 8] = b;
          WSEL_GI: gi_next[{head.sel[1:0], 3'b000} +: 8] = b;
          default: ;
        endcase
      end
      CLS_MAC: begin
        if (mac_byte != b) begin
          match_next = 1'b0;
        end
      end
      CLS_OPT: begin
        if (!ended) begin
          unique case (phase)
            PH_CODE: begin
              if (b == CODE_END) begin
                ended_next = 1'b1;
              end else if (b != CODE_PAD) begin
                code_next = b;
              end
            end
            PH_LEN: begin
              remaining_next   = b;
              value_index_next = 3'd0;
              case (code)
                CODE_MASK:  mask_next     = '0;
                CODE_DNS:   dns_next      = '0;
                CODE_LEASE: lease_next    = '0;
                CODE_TYPE:  msg_type_next = '0;
                default: ;
              endcase
            end
            PH_VALUE: begin
              if (!value_index[2]) begin
                case (code)
                  CODE_MASK:  mask_next[{value_index[1:0], 3'b000} +: 8] = b;
                  CODE_DNS:   dns_next[{value_index[1:0], 3'b000} +: 8]  = b;
                  CODE_LEASE: lease_next = {lease[23:0], b};
                  CODE_TYPE: begin
                    if (value_index == 3'd0) begin
                      msg_type_next = b;
                    end
                  end
                  default: ;
                endcase
                value_index_next = value_index + 3'd1;
              end
              remaining_next = remaining - 8'd1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result              = '0;
    result.mac_match    = match_next && head.hdr_done;
    result.message_type = msg_type_next;
    result.offered_ip   = yi_next;
    result.server_ip    = si_next;
    result.router_ip    = (gi_next != '0) ? gi_next : si_next;
    result.net_mask     = mask_next;
    result.dns_addr     = dns_next;
    result.lease_time   = lease_next;
    result.action       = ACT_IGNORE;
    if (result.mac_match) begin
      if (msg_type_next == TYPE_OFFER) begin
        result.action = ACT_REQUEST;
      end else if (msg_type_next == TYPE_ACK) begin
        result.action = ACT_APPLY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && head.last)) begin
      phase       <= PH_CODE;
      code        <= '0;
      remaining   <= '0;
      value_index <= '0;
      match       <= 1'b1;
      ended       <= 1'b0;
      msg_type    <= '0;
      yi          <= '0;
      si          <= '0;
      gi          <= '0;
      mask        <= '0;
      dns         <= '0;
      lease       <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      code        <= code_next;
      remaining   <= remaining_next;
      value_index <= value_index_next;
      match       <= match_next;
      ended       <= ended_next;
      msg_type    <= msg_type_next;
      yi          <= yi_next;
      si          <= si_next;
      gi          <= gi_next;
      mask        <= mask_next;
      dns         <= dns_next;
      lease       <= lease_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_result <= result;
    end
  end

endmodule

// File: design/dhcp_reply_option_parser_top.sv
// ----------------------------------------------------------------------------
// dhcp_reply_option_parser_top
// dhcp client reply parser: header capture, option walk and action report
// ----------------------------------------------------------------------------
// usage:
//   s_* carries the dhcp message one byte per item, starting right after the
//   udp header; s_tlast marks the final byte of the message.
//   m_* carries one result item per message, issued for the byte marked last.
//   the apb port holds station_mac at address 0, written while idle.
// result: the last byte is written to the tag queue, and the result register
//   loads the result item as that byte leaves the tag queue.
// throughput: one byte per cycle while results are taken, set by the
//   combinational tlv walk in the back end; messages may follow with no gap.
// reset: rst is synchronous; it empties the queue, drops any pending result
//   and returns the parser to the start of a message. station_mac clears.
// stall: while m_tready is low the result holds; bytes keep flowing into the
//   four-entry queue until the next last byte needs the result register,
//   after which s_tready drops once the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhcp_reply_option_parser_top #(
  parameter int MAX_MESSAGE_BYTES = 1500
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // data_byte
  input  logic          s_tlast,   // last_byte
  output logic          m_tvalid,
  input  logic          m_tready,
  // action[1:0], mac_match[2], message_type[10:3], offered_ip[42:11],
  // server_ip[74:43], router_ip[106:75], net_mask[138:107],
  // dns_addr[170:139], lease_time[202:171], zero fill[207:203]
  output logic [207:0]  m_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import drop_pkg::*;

  logic [47:0] station_mac;
  logic        push;
  item_t       push_item;
  logic        q_full;
  logic        pop;
  item_t       head;
  logic        q_empty;
  result_t     out_result;

  assign pready  = 1'b1;
  assign prdata  = (paddr[3] == 1'b0) ? {16'd0, station_mac} : 64'd0;
  assign m_tdata = out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_mac <= '0;
    end else if (psel && penable && pwrite && pready && paddr[3] == 1'b0) begin
      station_mac <= pwdata[47:0];
    end
  end

  drop_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .push     (push),
    .push_item(push_item),
    .q_full   (q_full)
  );

  drop_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  drop_back u_back (
    .clk        (clk),
    .rst        (rst),
    .station_mac(station_mac),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

endmodule

// File: design/drop_checker.sv
// ----------------------------------------------------------------------------
// drop_checker
// port-level checks on the result channel of the dhcp reply parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dhcp_reply_option_parser_top_defines.svh"

module drop_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [207:0] m_tdata
);
  import drop_pkg::*;

  `DROP_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `DROP_ASSERT_IMPLIES(a_act_code, clk, rst, m_tvalid, m_tdata[1:0] != 2'd3, "bad action code")
  `DROP_ASSERT_IMPLIES(a_act_match, clk, rst, m_tvalid && m_tdata[1:0] != ACT_IGNORE, m_tdata[2], "action without mac match")
  `DROP_ASSERT_IMPLIES(a_req_type, clk, rst, m_tvalid && m_tdata[1:0] == ACT_REQUEST, m_tdata[10:3] == TYPE_OFFER, "request without offer")

endmodule

bind dhcp_reply_option_parser_top drop_checker u_checker (.*);
